// File: sv/rgbtp_pkg.sv
// rgbtp_pkg: shared types, register map and defaults of the RGB gradient
// test-pattern generator. No dependencies.
`timescale 1ns / 1ps

package rgbtp_pkg;

    localparam int COORD_W   = 12;
    localparam int DIM_W     = 13;
    localparam int MAXV_W    = 10;
    localparam int SHIFTS_W  = 15;
    localparam int WORD_W    = 32;
    localparam int FMT_W     = 3;
    localparam int ADDR_W    = 5;
    localparam int SHAMT_W   = 5;
    localparam int NUM_LANES = 3;

    localparam int DEF_MAX_DIMENSION = 4096;
    localparam int DEF_CHANNEL_BITS  = 10;

    // register indexes, byte address is 4 * index
    localparam logic [2:0] REG_FRAME_WIDTH    = 3'd0;
    localparam logic [2:0] REG_FRAME_HEIGHT   = 3'd1;
    localparam logic [2:0] REG_RED_MAX        = 3'd2;
    localparam logic [2:0] REG_GREEN_MAX      = 3'd3;
    localparam logic [2:0] REG_BLUE_MAX       = 3'd4;
    localparam logic [2:0] REG_CHANNEL_SHIFTS = 3'd5;
    localparam logic [2:0] REG_ALPHA_BITS     = 3'd6;
    localparam logic [2:0] REG_PIXEL_BYTES    = 3'd7;

    // pixel formats
    localparam logic [FMT_W-1:0] FMT_2BYTE = 3'd2;
    localparam logic [FMT_W-1:0] FMT_3BYTE = 3'd3;
    localparam logic [FMT_W-1:0] FMT_4BYTE = 3'd4;

    // divider lanes
    localparam int LANE_RED   = 0;
    localparam int LANE_GREEN = 1;
    localparam int LANE_BLUE  = 2;

    typedef struct packed {
        logic [DIM_W-1:0]    frame_width;
        logic [DIM_W-1:0]    frame_height;
        logic [MAXV_W-1:0]   red_max;
        logic [MAXV_W-1:0]   green_max;
        logic [MAXV_W-1:0]   blue_max;
        logic [SHIFTS_W-1:0] channel_shifts;
        logic [WORD_W-1:0]   alpha_bits;
        logic [FMT_W-1:0]    pixel_bytes;
    } cfg_t;

    // control travelling with each request down the pipeline
    typedef struct packed {
        logic valid;
        logic outside;
    } stage_ctl_t;

endpackage

// File: sv/rgbtp_regs.sv
// rgbtp_regs: APB-style configuration register file.
// Depends on rgbtp_pkg.
`timescale 1ns / 1ps

module rgbtp_regs
    import rgbtp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                REG_FRAME_WIDTH:    cfg_next.frame_width    = pwdata[DIM_W-1:0];
                REG_FRAME_HEIGHT:   cfg_next.frame_height   = pwdata[DIM_W-1:0];
                REG_RED_MAX:        cfg_next.red_max        = pwdata[MAXV_W-1:0];
                REG_GREEN_MAX:      cfg_next.green_max      = pwdata[MAXV_W-1:0];
                REG_BLUE_MAX:       cfg_next.blue_max       = pwdata[MAXV_W-1:0];
                REG_CHANNEL_SHIFTS: cfg_next.channel_shifts = pwdata[SHIFTS_W-1:0];
                REG_ALPHA_BITS:     cfg_next.alpha_bits     = pwdata[WORD_W-1:0];
                REG_PIXEL_BYTES:    cfg_next.pixel_bytes    = pwdata[FMT_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_width    <= DIM_W'(640);
            cfg_reg.frame_height   <= DIM_W'(480);
            cfg_reg.red_max        <= MAXV_W'(255);
            cfg_reg.green_max      <= MAXV_W'(255);
            cfg_reg.blue_max       <= MAXV_W'(255);
            cfg_reg.channel_shifts <= SHIFTS_W'(4112);
            cfg_reg.alpha_bits     <= 32'hFF00_0000;
            cfg_reg.pixel_bytes    <= FMT_4BYTE;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_FRAME_WIDTH:    prdata = {{(32-DIM_W){1'b0}}, cfg_reg.frame_width};
            REG_FRAME_HEIGHT:   prdata = {{(32-DIM_W){1'b0}}, cfg_reg.frame_height};
            REG_RED_MAX:        prdata = {{(32-MAXV_W){1'b0}}, cfg_reg.red_max};
            REG_GREEN_MAX:      prdata = {{(32-MAXV_W){1'b0}}, cfg_reg.green_max};
            REG_BLUE_MAX:       prdata = {{(32-MAXV_W){1'b0}}, cfg_reg.blue_max};
            REG_CHANNEL_SHIFTS: prdata = {{(32-SHIFTS_W){1'b0}}, cfg_reg.channel_shifts};
            REG_ALPHA_BITS:     prdata = cfg_reg.alpha_bits;
            REG_PIXEL_BYTES:    prdata = {{(32-FMT_W){1'b0}}, cfg_reg.pixel_bytes};
            default:            prdata = '0;
        endcase
    end

endmodule

// File: sv/rgbtp_div_step.sv
// rgbtp_div_step: one restoring-division stage, one quotient bit per lane.
// Depends on rgbtp_pkg.
`timescale 1ns / 1ps

module rgbtp_div_step
    import rgbtp_pkg::*;
#(
    parameter int QUOT_W = DEF_CHANNEL_BITS
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  stage_ctl_t                           ctl_in,
    input  logic [NUM_LANES-1:0][DIM_W-1:0]      rem_in,
    input  logic [NUM_LANES-1:0][QUOT_W-1:0]     nq_in,
    input  logic [NUM_LANES-1:0][DIM_W-1:0]      divisor,
    output stage_ctl_t                           ctl_out,
    output logic [NUM_LANES-1:0][DIM_W-1:0]      rem_out,
    output logic [NUM_LANES-1:0][QUOT_W-1:0]     nq_out
);

    stage_ctl_t                       ctl_reg;
    logic [NUM_LANES-1:0][DIM_W-1:0]  rem_reg;
    logic [NUM_LANES-1:0][DIM_W-1:0]  rem_next;
    logic [NUM_LANES-1:0][QUOT_W-1:0] nq_reg;
    logic [NUM_LANES-1:0][QUOT_W-1:0] nq_next;

    // nq holds the numerator bits still to bring down, quotient bits enter at the bottom
    always_comb
    begin
        logic [DIM_W:0]  trial;
        logic [DIM_W:0]  diff;
        logic [QUOT_W:0] shifted;
        logic            ge;
        for (int l = 0; l < NUM_LANES; l++)
        begin
            trial       = {rem_in[l], nq_in[l][QUOT_W-1]};
            diff        = trial - {1'b0, divisor[l]};
            ge          = (trial >= {1'b0, divisor[l]});
            rem_next[l] = ge ? diff[DIM_W-1:0] : trial[DIM_W-1:0];
            shifted     = {nq_in[l], ge};
            nq_next[l]  = shifted[QUOT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        nq_reg  <= nq_next;
    end

    assign ctl_out = ctl_reg;
    assign rem_out = rem_reg;
    assign nq_out  = nq_reg;

endmodule

// File: sv/rgbtp_pack.sv
// rgbtp_pack: channel shift stage, then sum with alpha and format select.
// Depends on rgbtp_pkg.
`timescale 1ns / 1ps

module rgbtp_pack
    import rgbtp_pkg::*;
#(
    parameter int QUOT_W = DEF_CHANNEL_BITS
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  cfg_t                             cfg,
    input  stage_ctl_t                       ctl_in,
    input  logic [NUM_LANES-1:0][QUOT_W-1:0] quot,
    output logic                             done,
    output logic [WORD_W-1:0]                pixel_word,
    output logic                             out_of_frame
);

    stage_ctl_t                       ctl_reg;
    logic [NUM_LANES-1:0][WORD_W-1:0] sh_reg;
    logic [NUM_LANES-1:0][WORD_W-1:0] sh_next;
    logic                             done_reg;
    logic [WORD_W-1:0]                word_reg;
    logic [WORD_W-1:0]                word_next;
    logic                             oof_reg;
    logic [QUOT_W-1:0]                blue_val;
    logic [WORD_W-1:0]                sum;

    // blue ramps down: max minus quotient, never negative since quotient <= max
    assign blue_val = cfg.blue_max[QUOT_W-1:0] - quot[LANE_BLUE];

    always_comb
    begin
        sh_next[LANE_RED]   = {{(WORD_W-QUOT_W){1'b0}}, quot[LANE_RED]}
                              << cfg.channel_shifts[SHAMT_W-1:0];
        sh_next[LANE_GREEN] = {{(WORD_W-QUOT_W){1'b0}}, quot[LANE_GREEN]}
                              << cfg.channel_shifts[2*SHAMT_W-1:SHAMT_W];
        sh_next[LANE_BLUE]  = {{(WORD_W-QUOT_W){1'b0}}, blue_val}
                              << cfg.channel_shifts[3*SHAMT_W-1:2*SHAMT_W];
    end

    assign sum = sh_reg[LANE_RED] + sh_reg[LANE_GREEN] + sh_reg[LANE_BLUE] + cfg.alpha_bits;

    always_comb
    begin
        case (cfg.pixel_bytes)
            FMT_2BYTE:            word_next = {16'h0000, sum[15:0]};
            FMT_3BYTE, FMT_4BYTE: word_next = sum;
            default:              word_next = '0;
        endcase
        if (ctl_reg.outside)
        begin
            word_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            ctl_reg  <= ctl_in;
            done_reg <= ctl_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg   <= sh_next;
        word_reg <= word_next;
        oof_reg  <= ctl_reg.outside;
    end

    assign done         = done_reg;
    assign pixel_word   = word_reg;
    assign out_of_frame = oof_reg;

endmodule

// File: sv/rgb_gradient_test_pattern.sv
// RGB gradient test-pattern generator: coordinate in, packed pixel out.
// Pipeline: done rises once a request has passed one multiply stage, one divider stage per
// quotient bit (min(CHANNEL_BITS,10) bits), a shift stage and a sum stage.
// Throughput: one request per cycle; busy is never raised and the receiver cannot stall.
// Reset (rst_n, async low) clears all valid bits and loads the register defaults.
// Depends on rgbtp_pkg, rgbtp_regs, rgbtp_div_step, rgbtp_pack.
`timescale 1ns / 1ps

module rgb_gradient_test_pattern
    import rgbtp_pkg::*;
#(
    parameter int MAX_DIMENSION = DEF_MAX_DIMENSION,
    parameter int CHANNEL_BITS  = DEF_CHANNEL_BITS
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [COORD_W-1:0] pixel_x,
    input  logic [COORD_W-1:0] pixel_y,
    output logic               done,
    output logic [WORD_W-1:0]  pixel_word,
    output logic               out_of_frame,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int QW     = (CHANNEL_BITS < MAXV_W) ? CHANNEL_BITS : MAXV_W;
    localparam int PROD_W = COORD_W + QW;
    localparam int DIM_TOP = (2 ** DIM_W) - 1;
    localparam logic [DIM_W-1:0] DIM_CAP =
        DIM_W'((MAX_DIMENSION > DIM_TOP) ? DIM_TOP : MAX_DIMENSION);

    cfg_t             cfg;
    logic [DIM_W-1:0] width_c;
    logic [DIM_W-1:0] height_c;
    logic             accept;
    logic             outside;
    logic [NUM_LANES-1:0][DIM_W-1:0] divisor;
    logic [NUM_LANES-1:0][PROD_W-1:0] prod;

    stage_ctl_t                       ctl_pipe [0:QW];
    logic [NUM_LANES-1:0][DIM_W-1:0]  rem_pipe [0:QW];
    logic [NUM_LANES-1:0][QW-1:0]     nq_pipe  [0:QW];

    stage_ctl_t                       ctl0_reg;
    stage_ctl_t                       ctl0_next;
    logic [NUM_LANES-1:0][DIM_W-1:0]  rem0_reg;
    logic [NUM_LANES-1:0][DIM_W-1:0]  rem0_next;
    logic [NUM_LANES-1:0][QW-1:0]     nq0_reg;
    logic [NUM_LANES-1:0][QW-1:0]     nq0_next;

    rgbtp_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign width_c  = (cfg.frame_width  > DIM_CAP) ? DIM_CAP : cfg.frame_width;
    assign height_c = (cfg.frame_height > DIM_CAP) ? DIM_CAP : cfg.frame_height;

    // zero width or height puts every request outside, so no quotient from a zero divisor reaches pixel_word
    assign outside = ({{(DIM_W-COORD_W){1'b0}}, pixel_x} >= width_c)
                  || ({{(DIM_W-COORD_W){1'b0}}, pixel_y} >= height_c);

    assign divisor[LANE_RED]   = width_c;
    assign divisor[LANE_GREEN] = height_c;
    assign divisor[LANE_BLUE]  = width_c;

    assign prod[LANE_RED]   = PROD_W'(pixel_x * cfg.red_max[QW-1:0]);
    assign prod[LANE_GREEN] = PROD_W'(pixel_y * cfg.green_max[QW-1:0]);
    assign prod[LANE_BLUE]  = PROD_W'(pixel_x * cfg.blue_max[QW-1:0]);

    // coordinate < dimension keeps the top part below the divisor, so QW steps suffice
    always_comb
    begin
        ctl0_next.valid   = accept;
        ctl0_next.outside = outside;
        for (int l = 0; l < NUM_LANES; l++)
        begin
            rem0_next[l] = {{(DIM_W-COORD_W){1'b0}}, prod[l][PROD_W-1:QW]};
            nq0_next[l]  = prod[l][QW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl0_reg <= '0;
        end
        else
        begin
            ctl0_reg <= ctl0_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem0_reg <= rem0_next;
        nq0_reg  <= nq0_next;
    end

    assign ctl_pipe[0] = ctl0_reg;
    assign rem_pipe[0] = rem0_reg;
    assign nq_pipe[0]  = nq0_reg;

    for (genvar k = 0; k < QW; k++)
    begin : g_div
        rgbtp_div_step #(
            .QUOT_W (QW)
        ) u_step (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl_in  (ctl_pipe[k]),
            .rem_in  (rem_pipe[k]),
            .nq_in   (nq_pipe[k]),
            .divisor (divisor),
            .ctl_out (ctl_pipe[k+1]),
            .rem_out (rem_pipe[k+1]),
            .nq_out  (nq_pipe[k+1])
        );
    end

    rgbtp_pack #(
        .QUOT_W (QW)
    ) u_pack (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .ctl_in       (ctl_pipe[QW]),
        .quot         (nq_pipe[QW]),
        .done         (done),
        .pixel_word   (pixel_word),
        .out_of_frame (out_of_frame)
    );

endmodule

// File: sv/rgbtp_checker.sv
// rgbtp_checker: port-level assertions for the gradient generator, bound to the top.
// Depends on rgbtp_pkg and rgb_gradient_test_pattern.
`timescale 1ns / 1ps

module rgbtp_checker
    import rgbtp_pkg::*;
#(
    parameter int CHANNEL_BITS = DEF_CHANNEL_BITS
)
(
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              done,
    input logic [WORD_W-1:0] pixel_word,
    input logic              out_of_frame,
    input logic              pready
);

    localparam int QW  = (CHANNEL_BITS < MAXV_W) ? CHANNEL_BITS : MAXV_W;
    localparam int LAT = QW + 3;

    // every accepted request yields exactly one result
    a_req_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("accepted request did not produce a result");

    a_done_has_req: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAT))
        else $error("result without a matching request");

    a_oof_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && out_of_frame) |-> (pixel_word == '0))
        else $error("out-of-frame pixel is not zero");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready dropped");

endmodule

bind rgb_gradient_test_pattern rgbtp_checker #(
    .CHANNEL_BITS (CHANNEL_BITS)
) u_rgbtp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .done         (done),
    .pixel_word   (pixel_word),
    .out_of_frame (out_of_frame),
    .pready       (pready)
);
